// ===== hw/rtl/at_command_line_parser_unit_macros.svh =====
// Assertion macros for the AT command line parser unit.
`ifndef AT_COMMAND_LINE_PARSER_UNIT_MACROS_SVH
`define AT_COMMAND_LINE_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ATCLP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ATCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ATCLP_ASSERT_ALWAYS(lbl, cond, msg)
`define ATCLP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/atclp_pkg.sv =====
package atclp_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic        record_kind;
    logic [4:0]  first_value;
    logic [5:0]  second_value;
    logic [13:0] third_value;
  } out_word_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;
  localparam logic KIND_TIME    = 1'b0;
  localparam logic KIND_DATE    = 1'b1;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_LOW   = 8'h20;
  localparam logic [7:0] CHAR_HIGH  = 8'h7E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [13:0] MISSING_VALUE = 14'd6666;
  localparam logic [13:0] VALUE_CAP     = 14'd9999;

  localparam logic [13:0] HOUR_LIMIT   = 14'd24;
  localparam logic [13:0] MINUTE_LIMIT = 14'd60;
  localparam logic [13:0] DAY_LIMIT    = 14'd30;
  localparam logic [13:0] MONTH_LIMIT  = 14'd13;
  localparam logic [13:0] YEAR_LIMIT   = 14'd9999;

  localparam logic [1:0] CMD_TIME  = 2'd0;
  localparam logic [1:0] CMD_DATE  = 2'd1;
  localparam logic [1:0] CMD_ALARM = 2'd2;
  localparam int unsigned CMD_COUNT = 3;

  localparam logic [7:0] CMD_TEXT [0:2][0:7] = '{
    '{"A", "T", "+", "T", "I", "M", "E", 8'h00},
    '{"A", "T", "+", "D", "A", "T", "E", 8'h00},
    '{"A", "T", "+", "A", "L", "A", "R", "M"}
  };
  localparam logic [3:0] CMD_LEN [0:2] = '{4'd7, 4'd7, 4'd8};

  function automatic logic [7:0] cmd_char(input logic [1:0] k, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < CMD_LEN[k]) begin
      ch = CMD_TEXT[k][pos[2:0]];
    end
    return ch;
  endfunction

endpackage

// ===== hw/rtl/atclp_stream_if.sv =====
interface atclp_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/atclp_parser.sv =====
module atclp_parser
  import atclp_pkg::*;
#(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       done,
  output out_word_t  result
);

  localparam int unsigned CNT_W = $clog2(LINE_MAX + 1);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_CMD,
    PH_FIELDS
  } phase_t;

  logic [CNT_W-1:0] count_r, count_nxt;
  phase_t           phase_r, phase_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [2:0]       alive_r, alive_nxt;
  logic [1:0]       fidx_r, fidx_nxt;
  logic [13:0]      acc_r [0:2];
  logic [13:0]      acc_nxt [0:2];
  logic [2:0]       alld_r, alld_nxt;
  logic [2:0]       pres_r, pres_nxt;
  logic             intok_r, intok_nxt;

  logic        full, is_cr, is_eq, is_comma, is_digit, printable;
  logic [2:0]  hit, len_ok;
  logic [3:0]  pos_inc;
  logic [13:0] acc_sel, acc_sat;
  logic [16:0] acc_prod;
  logic [13:0] val [0:2];
  logic        ok;

  assign full      = count_r >= CNT_W'(LINE_MAX);
  assign is_cr     = rx_byte == CHAR_CR;
  assign is_eq     = rx_byte == CHAR_EQ;
  assign is_comma  = rx_byte == CHAR_COMMA;
  assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign printable = (rx_byte >= CHAR_LOW) && (rx_byte <= CHAR_HIGH);
  assign pos_inc   = (pos_r == 4'hF) ? pos_r : pos_r + 4'd1;

  always_comb begin
    for (int k = 0; k < CMD_COUNT; k++) begin
      hit[k]    = cmd_char(2'(k), pos_r) == rx_byte;
      len_ok[k] = pos_r == CMD_LEN[k];
    end
  end

  always_comb begin
    case (fidx_r)
      2'd0:    acc_sel = acc_r[0];
      2'd1:    acc_sel = acc_r[1];
      2'd2:    acc_sel = acc_r[2];
      default: acc_sel = '0;
    endcase
    acc_prod = {3'b000, acc_sel} * 17'd10 + {13'd0, rx_byte[3:0]};
    acc_sat  = (acc_prod > {3'b000, VALUE_CAP}) ? VALUE_CAP : acc_prod[13:0];
  end

  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    fidx_nxt  = fidx_r;
    acc_nxt   = acc_r;
    alld_nxt  = alld_r;
    pres_nxt  = pres_r;
    intok_nxt = intok_r;
    done      = 1'b0;
    if (take) begin
      if (full || (is_cr && (count_r != '0))) begin
        done      = 1'b1;
        count_nxt = '0;
        phase_nxt = PH_SKIP;
        pos_nxt   = '0;
        alive_nxt = 3'b111;
        fidx_nxt  = '0;
        acc_nxt   = '{default: '0};
        alld_nxt  = 3'b111;
        pres_nxt  = '0;
        intok_nxt = 1'b0;
      end else if (printable) begin
        count_nxt = count_r + CNT_W'(1);
        case (phase_r)
          PH_SKIP: begin
            if (!is_eq) begin
              phase_nxt = PH_CMD;
              alive_nxt = alive_r & hit;
              pos_nxt   = pos_inc;
            end
          end
          PH_CMD: begin
            if (is_eq) begin
              alive_nxt = alive_r & len_ok;
              phase_nxt = PH_FIELDS;
            end else begin
              alive_nxt = alive_r & hit;
              pos_nxt   = pos_inc;
            end
          end
          PH_FIELDS: begin
            if (is_comma) begin
              if (intok_r) begin
                intok_nxt = 1'b0;
                if (fidx_r != 2'd3) begin
                  fidx_nxt = fidx_r + 2'd1;
                end
              end
            end else if (fidx_r != 2'd3) begin
              intok_nxt        = 1'b1;
              pres_nxt[fidx_r] = 1'b1;
              if (is_digit) begin
                acc_nxt[fidx_r] = acc_sat;
              end else begin
                alld_nxt[fidx_r] = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    for (int k = 0; k < CMD_COUNT; k++) begin
      val[k] = (pres_r[k] && alld_r[k]) ? acc_r[k] : MISSING_VALUE;
    end
    ok     = 1'b0;
    result = '0;
    result.status = STATUS_ERROR;
    if (phase_r == PH_FIELDS) begin
      if (alive_r[CMD_TIME]) begin
        ok = (val[0] < HOUR_LIMIT) && (val[1] < MINUTE_LIMIT) && (val[2] < MINUTE_LIMIT);
        if (ok) begin
          result.record_kind  = KIND_TIME;
          result.third_value  = val[2];
        end
      end else if (alive_r[CMD_DATE]) begin
        ok = (val[0] < DAY_LIMIT) && (val[1] < MONTH_LIMIT) && (val[2] < YEAR_LIMIT);
        if (ok) begin
          result.record_kind  = KIND_DATE;
          result.third_value  = val[2];
        end
      end else if (alive_r[CMD_ALARM]) begin
        ok = (val[0] < HOUR_LIMIT) && (val[1] < MINUTE_LIMIT);
        if (ok) begin
          result.record_kind  = KIND_TIME;
          result.third_value  = '0;
        end
      end
    end
    if (ok) begin
      result.status       = STATUS_OK;
      result.first_value  = val[0][4:0];
      result.second_value = val[1][5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= PH_SKIP;
      pos_r   <= '0;
      alive_r <= 3'b111;
      fidx_r  <= '0;
      acc_r   <= '{default: '0};
      alld_r  <= 3'b111;
      pres_r  <= '0;
      intok_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
      fidx_r  <= fidx_nxt;
      acc_r   <= acc_nxt;
      alld_r  <= alld_nxt;
      pres_r  <= pres_nxt;
      intok_r <= intok_nxt;
    end
  end

endmodule

// ===== hw/rtl/at_command_line_parser_unit.sv =====
// Channel   Dir  Payload                                          Word moved when
// in_ch     in   rx_byte[7:0]                                     valid && ready
// out_ch    out  status, record_kind, first_value[4:0],           valid && ready
//                second_value[5:0], third_value[13:0]
//
// One received word per cycle while in_ch.ready is high; a finished line shows its response in the cycle
// after the word that ends it, through the output register.
// Synchronous active-low reset clears the line state and empties the output register.
// in_ch.ready is low only while a response waits in the output register and out_ch.ready
// is low; every word taken while the output register is free or draining is processed.
`include "at_command_line_parser_unit_macros.svh"

module at_command_line_parser_unit
  import atclp_pkg::*;
#(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  atclp_stream_if.sink     in_ch,
  atclp_stream_if.source   out_ch
);

  logic      take, done;
  out_word_t result;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  atclp_parser #(
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_ch.data.rx_byte),
    .done    (done),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (take && done) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `ATCLP_ASSERT_NEXT(a_done_loads, take && done, out_valid_r, "finished line lost")
  `ATCLP_ASSERT_ALWAYS(a_ok_range, !(out_valid_r && out_data_r.status == STATUS_OK) || (out_data_r.first_value < 5'd30 && out_data_r.second_value < 6'd60), "OK response out of range")
  `ATCLP_ASSERT_ALWAYS(a_error_zero, !(out_valid_r && out_data_r.status == STATUS_ERROR) || (out_data_r.record_kind == KIND_TIME && out_data_r.first_value == '0 && out_data_r.second_value == '0 && out_data_r.third_value == '0), "ERROR response carries data")

endmodule
